### rtl/lket_pkg.sv
// ----------------------------------------------------------------------------
// lket_pkg
// Shared types and constants for the LRU key eviction tracker.
// ----------------------------------------------------------------------------
package lket_pkg;

    localparam int ENTRIES     = 16;               // slots in the table
    localparam int KEY_BITS    = 64;               // stored key width
    localparam int KEY_FIELD_W = 64;               // key field on the ports
    localparam int RANK_W      = 64;               // rank counter width
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int SCAN_W      = $clog2(ENTRIES);

    typedef logic [KEY_BITS-1:0]    t_key;
    typedef logic [KEY_FIELD_W-1:0] t_key_field;
    typedef logic [RANK_W-1:0]      t_rank;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [SCAN_W-1:0]      t_scan;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REFRESH = 3'd1,
        OP_DELETE  = 3'd2,
        OP_EVICT   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_DUP       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // Running-minimum token passed from cell to cell
    typedef struct packed {
        logic  vld;
        t_rank rank;
        t_key  key;
        t_idx  idx;
    } t_tok;

    // Broadcast update controls, applied in the commit cycle
    typedef struct packed {
        logic  add_en;
        logic  refresh_en;
        logic  delete_en;
        logic  evict_en;
        logic  clear_en;
        t_key  key;
        t_rank rank;
        t_idx  evict_idx;
    } t_cell_ctl;

endpackage

### rtl/lket_if.sv
// ----------------------------------------------------------------------------
// lket_op_if / lket_res_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface lket_op_if;
    logic                                valid;
    logic                                ready;
    logic [lket_pkg::OP_W-1:0]           opcode;
    logic [lket_pkg::KEY_FIELD_W-1:0]    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface lket_res_if;
    logic                                valid;
    logic                                ready;
    logic [lket_pkg::STATUS_W-1:0]       status;
    logic [lket_pkg::KEY_FIELD_W-1:0]    evicted_key;

    modport source (output valid, output status, output evicted_key, input ready);
    modport sink   (input valid, input status, input evicted_key, output ready);
endinterface

### rtl/lket_cell.sv
// ----------------------------------------------------------------------------
// lket_cell
// One table slot: key, rank, valid, plus one stage of the min-rank chain.
// ----------------------------------------------------------------------------
module lket_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lket_pkg::t_idx        i_idx,
    input  lket_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_free_seen,
    output logic                  o_free_seen,
    output logic                  o_match,
    input  lket_pkg::t_tok        i_tok,
    output lket_pkg::t_tok        o_tok
);
    import lket_pkg::*;

    logic   r_valid;
    t_key   r_key;
    t_rank  r_rank;
    t_tok   r_tok;
    t_tok   n_tok;
    logic   w_take;

    assign o_match     = r_valid && (r_key == i_ctl.key);
    assign o_free_seen = i_free_seen || !r_valid;
    // lowest free slot: free here, none free upstream
    assign w_take      = !r_valid && !i_free_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear_en) begin
            r_valid <= 1'b0;
        end else if (i_ctl.add_en && w_take) begin
            r_valid <= 1'b1;
        end else if (i_ctl.delete_en && o_match) begin
            r_valid <= 1'b0;
        end else if (i_ctl.evict_en && (i_ctl.evict_idx == i_idx)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en && w_take) begin
            r_key  <= i_ctl.key;
            r_rank <= i_ctl.rank;
        end else if (i_ctl.refresh_en && o_match) begin
            r_rank <= i_ctl.rank;
        end
    end

    // strict compare: on a tie the upstream (lower) slot keeps the token
    always_comb begin
        n_tok = i_tok;
        if (r_valid && (!i_tok.vld || (r_rank < i_tok.rank))) begin
            n_tok.vld  = 1'b1;
            n_tok.rank = r_rank;
            n_tok.key  = r_key;
            n_tok.idx  = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/lru_key_eviction_tracker.sv
// ----------------------------------------------------------------------------
// lru_key_eviction_tracker
// LRU bookkeeping over a row of slot cells with a systolic min-rank chain.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                     word
//  -------  ---  -------------------------  --------------------------------
//  i_op     in   opcode[2:0], key[63:0]     one operation
//  o_res    out  status[2:0], evicted[63:0] one result per operation
//
//  Add, refresh, delete, clear and unused opcodes skip the scan: accept, then
//  a commit cycle that updates the cells and loads the result register.
//  Evict first scans: the oldest slot is found by a running
//  minimum that moves one cell per cycle down the chain.
//  Reset clears all valid bits and the rank counter; no clearing pass.
//  One word in flight; a result held by a stalled o_res blocks the commit.
//
module lru_key_eviction_tracker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lket_op_if.sink         i_op,
    lket_res_if.source      o_res
);
    import lket_pkg::*;

    // control
    t_state               r_state;
    t_state               n_state;
    t_scan                r_cnt;
    logic                 w_commit;

    // latched operation
    logic [OP_W-1:0]      r_op;
    t_key                 r_key;
    t_rank                r_rank;

    // result register
    logic                 r_out_vld;
    logic [STATUS_W-1:0]  r_status;
    t_key_field           r_evict;
    t_status              w_status;
    t_key_field           w_evict;

    // cell row
    t_cell_ctl            w_ctl;
    t_tok                 w_tok  [ENTRIES+1];
    logic                 w_free [ENTRIES+1];
    logic [ENTRIES-1:0]   w_match;
    logic                 w_dup;
    logic                 w_full;
    t_tok                 w_oldest;

    assign w_tok[0]  = '0;
    assign w_free[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lket_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (IDX_W'(g)),
            .i_ctl       (w_ctl),
            .i_free_seen (w_free[g]),
            .o_free_seen (w_free[g+1]),
            .o_match     (w_match[g]),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1])
        );
    end

    assign w_dup    = |w_match;          // stored keys are unique
    assign w_full   = !w_free[ENTRIES];
    assign w_oldest = w_tok[ENTRIES];

    assign i_op.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.status      = r_status;
    assign o_res.evicted_key = r_evict;

    assign w_commit = (r_state == S_EXEC) && (!r_out_vld || o_res.ready);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_op.valid) begin
                    n_state = (i_op.opcode == OP_EVICT) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                // wait for the running minimum to leave the last cell
                if (r_cnt == SCAN_W'(ENTRIES - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs: result and cell controls ----
    always_comb begin
        w_status        = STAT_OK;
        w_evict         = '0;
        w_ctl           = '0;
        w_ctl.key       = r_key;
        w_ctl.rank      = r_rank;
        w_ctl.evict_idx = w_oldest.idx;
        unique case (r_op)
            OP_ADD: begin
                if (w_dup) begin
                    w_status = STAT_DUP;
                end else if (w_full) begin
                    w_status = STAT_FULL;
                end
                w_ctl.add_en = w_commit && !w_dup;
            end
            OP_REFRESH: begin
                if (!w_dup) begin
                    w_status = STAT_NOT_FOUND;
                end
                w_ctl.refresh_en = w_commit;
            end
            OP_DELETE: begin
                w_ctl.delete_en = w_commit;
            end
            OP_EVICT: begin
                if (w_oldest.vld) begin
                    w_evict = KEY_FIELD_W'(w_oldest.key);
                end else begin
                    w_status = STAT_EMPTY;
                end
                w_ctl.evict_en = w_commit && w_oldest.vld;
            end
            OP_CLEAR: begin
                w_ctl.clear_en = w_commit;
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rank    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + SCAN_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
                unique case (r_op)
                    OP_ADD, OP_REFRESH: r_rank <= r_rank + RANK_W'(1);
                    OP_CLEAR:           r_rank <= '0;
                    default:            r_rank <= r_rank;
                endcase
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.valid && i_op.ready) begin
            r_op  <= i_op.opcode;
            r_key <= KEY_BITS'(i_op.key);
        end
        if (w_commit) begin
            r_status <= w_status;
            r_evict  <= w_evict;
        end
    end

endmodule
